@@ rtl/core/hsv_to_rgb_led_color_macros.svh @@
// Assertion macros used by the color converter top level.
`ifndef HSV_TO_RGB_LED_COLOR_MACROS_SVH
`define HSV_TO_RGB_LED_COLOR_MACROS_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define HSVRGB_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HSVRGB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/hsvrgb_pkg.sv @@
// Types, codes and constants of the HSV to RGB converter.
package hsvrgb_pkg;

  typedef enum logic [1:0] {
    MODE_RAW      = 2'd0,
    MODE_SPECTRUM = 2'd1,
    MODE_RAINBOW  = 2'd2,
    MODE_RAINBOW_ALT = 2'd3
  } mode_t;

  localparam mode_t MODE_RESET = MODE_RAINBOW;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] SPECTRUM_SCALE = 8'd191;
  localparam logic [7:0] FULL_LEVEL     = 8'd255;
  localparam logic [5:0] RAW_OFFSET_MAX = 6'h3F;
  localparam logic [7:0] THIRD_LEVEL    = 8'd85;
  localparam logic [7:0] TWO_THIRDS     = 8'd170;
  localparam logic [7:0] TWO_THIRDS_UP  = 8'd171;

  localparam int CFG_ADDR_W = 3;
  localparam logic [0:0] REG_CONVERSION_MODE = 1'b0;

  // One classified request waiting for the back end.
  typedef struct packed {
    logic       rainbow;
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
    logic [7:0] flr;
    logic [7:0] ds;
    logic [7:0] vv;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  // (a*b)>>8 on 8-bit operands
  function automatic logic [7:0] scale8(input logic [7:0] a, input logic [7:0] b);
    logic [15:0] p;
    p = 16'(a) * 16'(b);
    return p[15:8];
  endfunction

  // (a*b)>>8, plus one when both operands are nonzero
  function automatic logic [7:0] scale8_round(input logic [7:0] a, input logic [7:0] b);
    logic [15:0] p;
    p = 16'(a) * 16'(b);
    return p[15:8] + {7'd0, (a != 8'd0) && (b != 8'd0)};
  endfunction

endpackage

@@ rtl/core/hsvrgb_front.sv @@
// Front end: takes a request, scales the hue in spectrum mode and forms floor and square terms.
module hsvrgb_front (
  input  logic                     start,
  input  logic [7:0]               hue,
  input  logic [7:0]               saturation,
  input  logic [7:0]               brightness,
  input  hsvrgb_pkg::mode_t        mode,
  input  hsvrgb_pkg::queue_stat_t  stat,
  output logic                     busy,
  output logic                     push,
  output hsvrgb_pkg::entry_t       entry
);

  logic [7:0] sat_inv;

  assign busy    = stat.full;
  assign push    = start && !stat.full;
  assign sat_inv = hsvrgb_pkg::FULL_LEVEL - saturation;

  always_comb begin
    entry            = '0;
    entry.saturation = saturation;
    entry.brightness = brightness;
    entry.flr        = hsvrgb_pkg::scale8(brightness, sat_inv);
    entry.ds         = hsvrgb_pkg::scale8_round(sat_inv, sat_inv);
    entry.vv         = hsvrgb_pkg::scale8_round(brightness, brightness);
    unique case (mode)
      hsvrgb_pkg::MODE_RAW: begin
        entry.rainbow = 1'b0;
        entry.hue     = hue;
      end
      hsvrgb_pkg::MODE_SPECTRUM: begin
        entry.rainbow = 1'b0;
        entry.hue     = hsvrgb_pkg::scale8(hue, hsvrgb_pkg::SPECTRUM_SCALE);
      end
      default: begin
        entry.rainbow = 1'b1;
        entry.hue     = hue;
      end
    endcase
  end

endmodule

@@ rtl/core/hsvrgb_queue.sv @@
// Short request queue between the front and back ends.
module hsvrgb_queue #(
  parameter int DEPTH = hsvrgb_pkg::QUEUE_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  hsvrgb_pkg::entry_t       push_entry,
  input  logic                     pop,
  output hsvrgb_pkg::entry_t       head,
  output hsvrgb_pkg::queue_stat_t  stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  hsvrgb_pkg::entry_t slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_pop;

  assign stat.full  = (count == CW'(DEPTH));
  assign stat.empty = (count == '0);
  assign do_pop     = pop && !stat.empty;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

@@ rtl/core/hsvrgb_back.sv @@
// Back end: three-stage color pipeline, base color, desaturation, dimming.
module hsvrgb_back (
  input  logic                     clk,
  input  logic                     rst,
  input  hsvrgb_pkg::queue_stat_t  stat,
  input  hsvrgb_pkg::entry_t       head,
  output logic                     pop,
  output logic                     done,
  output logic [7:0]               red,
  output logic [7:0]               green,
  output logic [7:0]               blue
);

  typedef enum logic [1:0] {SAT_PASS, SAT_WHITE, SAT_MIX} sat_op_t;
  typedef enum logic [1:0] {VAL_PASS, VAL_ZERO, VAL_SCALE} val_op_t;

  // stage 1: base color
  logic [7:0] raw_amp;
  logic [5:0] raw_off;
  logic [13:0] up_p;
  logic [13:0] dn_p;
  logic [7:0] raw_up;
  logic [7:0] raw_dn;
  logic [7:0] off8;
  logic [7:0] th;
  logic [7:0] tw;
  logic [7:0] c_r, c_g, c_b;
  sat_op_t    sat_op;
  val_op_t    val_op;

  logic       s1_valid;
  logic [7:0] s1_r, s1_g, s1_b;
  sat_op_t    s1_sat_op;
  val_op_t    s1_val_op;
  logic [7:0] s1_ds;
  logic [7:0] s1_vv;

  logic       s2_valid;
  logic [7:0] s2_r, s2_g, s2_b;
  val_op_t    s2_val_op;
  logic [7:0] s2_vv;

  logic [7:0] ss;
  logic [7:0] m_r, m_g, m_b;
  logic [7:0] d_r, d_g, d_b;

  assign pop = !stat.empty;

  assign raw_amp = head.brightness - head.flr;
  assign raw_off = head.hue[5:0];
  assign up_p    = 14'(raw_off) * 14'(raw_amp);
  assign dn_p    = 14'(hsvrgb_pkg::RAW_OFFSET_MAX - raw_off) * 14'(raw_amp);
  assign raw_up  = up_p[13:6] + head.flr;
  assign raw_dn  = dn_p[13:6] + head.flr;

  assign off8 = {head.hue[4:0], 3'b000};
  assign th   = hsvrgb_pkg::scale8(off8, hsvrgb_pkg::THIRD_LEVEL);
  assign tw   = hsvrgb_pkg::scale8(off8, hsvrgb_pkg::TWO_THIRDS);

  always_comb begin
    c_r    = '0;
    c_g    = '0;
    c_b    = '0;
    sat_op = SAT_PASS;
    val_op = VAL_PASS;
    if (!head.rainbow) begin
      unique case (head.hue[7:6])
        2'd0: begin
          c_r = raw_dn; c_g = raw_up; c_b = head.flr;
        end
        2'd1: begin
          c_r = head.flr; c_g = raw_dn; c_b = raw_up;
        end
        2'd2: begin
          c_r = raw_up; c_g = head.flr; c_b = raw_dn;
        end
        default: begin
          c_r = '0; c_g = '0; c_b = '0;
        end
      endcase
    end else begin
      unique case (head.hue[7:5])
        3'd0: begin
          c_r = hsvrgb_pkg::FULL_LEVEL - th; c_g = th; c_b = '0;
        end
        3'd1: begin
          c_r = hsvrgb_pkg::TWO_THIRDS_UP; c_g = hsvrgb_pkg::THIRD_LEVEL + th; c_b = '0;
        end
        3'd2: begin
          c_r = hsvrgb_pkg::TWO_THIRDS_UP - tw; c_g = hsvrgb_pkg::TWO_THIRDS + th;
          c_b = '0;
        end
        3'd3: begin
          c_r = '0; c_g = hsvrgb_pkg::FULL_LEVEL - th; c_b = th;
        end
        3'd4: begin
          c_r = '0; c_g = hsvrgb_pkg::TWO_THIRDS_UP - tw;
          c_b = hsvrgb_pkg::THIRD_LEVEL + tw;
        end
        3'd5: begin
          c_r = th; c_g = '0; c_b = hsvrgb_pkg::FULL_LEVEL - th;
        end
        3'd6: begin
          c_r = hsvrgb_pkg::THIRD_LEVEL + th; c_g = '0;
          c_b = hsvrgb_pkg::TWO_THIRDS_UP - th;
        end
        default: begin
          c_r = hsvrgb_pkg::TWO_THIRDS + th; c_g = '0;
          c_b = hsvrgb_pkg::THIRD_LEVEL - th;
        end
      endcase
      priority if (head.saturation == hsvrgb_pkg::FULL_LEVEL) begin
        sat_op = SAT_PASS;
      end else if (head.saturation == 8'd0) begin
        sat_op = SAT_WHITE;
      end else begin
        sat_op = SAT_MIX;
      end
      priority if (head.brightness == hsvrgb_pkg::FULL_LEVEL) begin
        val_op = VAL_PASS;
      end else if (head.vv == 8'd0) begin
        val_op = VAL_ZERO;
      end else begin
        val_op = VAL_SCALE;
      end
    end
  end

  // stage 2: pull toward white by the squared desaturation
  assign ss  = hsvrgb_pkg::FULL_LEVEL - s1_ds;
  assign m_r = hsvrgb_pkg::scale8(s1_r, ss) + s1_ds;
  assign m_g = hsvrgb_pkg::scale8(s1_g, ss) + s1_ds;
  assign m_b = hsvrgb_pkg::scale8(s1_b, ss) + s1_ds;

  // stage 3: dim by the squared brightness
  assign d_r = hsvrgb_pkg::scale8(s2_r, s2_vv);
  assign d_g = hsvrgb_pkg::scale8(s2_g, s2_vv);
  assign d_b = hsvrgb_pkg::scale8(s2_b, s2_vv);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= pop;
      s2_valid <= s1_valid;
      done     <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_r      <= c_r;
    s1_g      <= c_g;
    s1_b      <= c_b;
    s1_sat_op <= sat_op;
    s1_val_op <= val_op;
    s1_ds     <= head.ds;
    s1_vv     <= head.vv;

    s2_val_op <= s1_val_op;
    s2_vv     <= s1_vv;
    unique case (s1_sat_op)
      SAT_WHITE: begin
        s2_r <= hsvrgb_pkg::FULL_LEVEL;
        s2_g <= hsvrgb_pkg::FULL_LEVEL;
        s2_b <= hsvrgb_pkg::FULL_LEVEL;
      end
      SAT_MIX: begin
        s2_r <= m_r;
        s2_g <= m_g;
        s2_b <= m_b;
      end
      default: begin
        s2_r <= s1_r;
        s2_g <= s1_g;
        s2_b <= s1_b;
      end
    endcase

    unique case (s2_val_op)
      VAL_ZERO: begin
        red   <= '0;
        green <= '0;
        blue  <= '0;
      end
      VAL_SCALE: begin
        red   <= d_r;
        green <= d_g;
        blue  <= d_b;
      end
      default: begin
        red   <= s2_r;
        green <= s2_g;
        blue  <= s2_b;
      end
    endcase
  end

endmodule

@@ rtl/core/hsv_to_rgb_led_color.sv @@
// Top level of the HSV to RGB converter: config register, front, queue, back.
//
//  channel   | handshake              | payload
//  ----------+------------------------+-------------------------------
//  request   | start / busy           | hue, saturation, brightness
//  result    | done (one-cycle pulse) | red, green, blue
//  config    | psel/penable/pwrite    | paddr, pwdata, prdata, pready
//
// One request per clock while busy is low; each result passes the queue slot and
// then the three back-end stages (base color, desaturation, dimming).
// The front end's multipliers feed the queue, which the back end drains
// every cycle, so busy only rises if the queue ever fills.
// Reset clears the queue, the stage valid bits and sets mode to rainbow.
// The receiver cannot stall: done lasts one cycle.
module hsv_to_rgb_led_color #(
  parameter int QUEUE_DEPTH = hsvrgb_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [7:0]                        hue,
  input  logic [7:0]                        saturation,
  input  logic [7:0]                        brightness,
  output logic                              done,
  output logic [7:0]                        red,
  output logic [7:0]                        green,
  output logic [7:0]                        blue,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [hsvrgb_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  hsvrgb_pkg::mode_t       mode;
  hsvrgb_pkg::queue_stat_t stat;
  hsvrgb_pkg::entry_t      push_entry;
  hsvrgb_pkg::entry_t      head;
  logic                    push;
  logic                    pop;
  logic                    cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == hsvrgb_pkg::REG_CONVERSION_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= hsvrgb_pkg::MODE_RESET;
    end else if (cfg_wr) begin
      mode <= hsvrgb_pkg::mode_t'(pwdata[1:0]);
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == hsvrgb_pkg::REG_CONVERSION_MODE) begin
      prdata = {30'd0, mode};
    end
  end

  hsvrgb_front u_front (
    .start      (start),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .mode       (mode),
    .stat       (stat),
    .busy       (busy),
    .push       (push),
    .entry      (push_entry)
  );

  hsvrgb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .stat       (stat)
  );

  hsvrgb_back u_back (
    .clk   (clk),
    .rst   (rst),
    .stat  (stat),
    .head  (head),
    .pop   (pop),
    .done  (done),
    .red   (red),
    .green (green),
    .blue  (blue)
  );

`include "hsv_to_rgb_led_color_macros.svh"

  `HSVRGB_ASSERT_IMPL(a_done_has_request, done, $past(start && !busy, 4), "result without request")
  `HSVRGB_ASSERT_IMPL(a_queue_drains, 1'b1, !busy, "queue filled although back end drains")
  `HSVRGB_ASSERT_NEXT(a_push_pops, push && stat.empty, !stat.empty && pop, "queued request not taken")
  `HSVRGB_ASSERT_IMPL(a_raw_black, done && $past(push && mode == hsvrgb_pkg::MODE_RAW && hue[7:6] == 2'b11, 4), red == 8'd0 && green == 8'd0 && blue == 8'd0, "raw hue past range not black")

endmodule
